FILE: hdl/mtf_pkg.sv
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared types and codes for the move-to-front recency list.
// ----------------------------------------------------------------------------
package mtf_pkg;

  // default list depth and stored id width
  localparam int unsigned DEPTH_DEF    = 16;
  localparam int unsigned ID_WIDTH_DEF = 16;

  // request codes
  typedef enum logic [1:0] {
    REQ_OPEN   = 2'd0,
    REQ_SWITCH = 2'd1,
    REQ_CLOSE  = 2'd2,
    REQ_NOP    = 2'd3
  } req_code_t;

  // status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // one request
  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] win_id;
  } req_t;

  // one result
  typedef struct packed {
    logic [15:0] front_id;
    logic        list_empty;
    logic [4:0]  entry_count;
    logic [1:0]  status;
  } rsp_t;

endpackage

FILE: hdl/mtf_ram.sv
// ----------------------------------------------------------------------------
// mtf_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mtf_ram #(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned ID_WIDTH = 16,
  localparam int unsigned IDX_W   = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [IDX_W-1:0]    waddr,
  input  logic [ID_WIDTH-1:0] wdata,
  input  logic [IDX_W-1:0]    raddr,
  output logic [ID_WIDTH-1:0] rdata
);

  logic [ID_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/move_to_front_recency_list.sv
// ----------------------------------------------------------------------------
// move_to_front_recency_list
// Recency list of up to DEPTH ids, most recent first, with open, switch and
// close requests.
// sequence: open shifts each held entry one place back, writes the front;
//   switch makes a scan pass, then a shift pass, and writes the front;
//   close makes a scan pass, then moves the entries behind the match up;
//   a miss stops after the scan; full, empty and no-op go to the result.
// throughput: one request at a time; busy stays high until the result cycle
//   ends. the entry store, one read and one write a cycle, sets the pace.
// reset: rst clears the entry count and the sequencer; the store is not
//   cleared, since entries beyond the count are never used.
// the result is shown for one cycle on done; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module move_to_front_recency_list #(
  parameter int unsigned DEPTH    = mtf_pkg::DEPTH_DEF,
  parameter int unsigned ID_WIDTH = mtf_pkg::ID_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  mtf_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output mtf_pkg::rsp_t rsp
);

  import mtf_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_MOVE  = 6'b000100,
    S_WR0   = 6'b001000,
    S_FRONT = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t state, state_next;

  // control state
  logic [CNT_W-1:0] held, held_next;       // entries held
  logic [CNT_W-1:0] scan_rd, scan_rd_next; // next index to read during scan
  logic             cmp_pend, cmp_pend_next;
  logic [CNT_W-1:0] cnt, cnt_next;         // entries left to copy
  logic             wr_pend, wr_pend_next;

  // working registers of the current request
  req_code_t           op, op_next;
  logic [ID_WIDTH-1:0] id, id_next;
  status_t             status, status_next;
  logic [IDX_W-1:0]    cmp_idx, cmp_idx_next;
  logic [IDX_W-1:0]    cur, cur_next;         // read address of the copy walk
  logic [IDX_W-1:0]    wr_addr, wr_addr_next; // destination of the pending copy
  logic                dir_dn, dir_dn_next;   // 1: entries move toward the back

  // store port
  logic                we;
  logic [IDX_W-1:0]    waddr;
  logic [ID_WIDTH-1:0] wdata;
  logic [IDX_W-1:0]    raddr;
  logic [ID_WIDTH-1:0] rdata;

  mtf_ram #(
    .DEPTH    (DEPTH),
    .ID_WIDTH (ID_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next    = state;
    held_next     = held;
    scan_rd_next  = scan_rd;
    cmp_pend_next = cmp_pend;
    cnt_next      = cnt;
    wr_pend_next  = wr_pend;
    op_next       = op;
    id_next       = id;
    status_next   = status;
    cmp_idx_next  = cmp_idx;
    cur_next      = cur;
    wr_addr_next  = wr_addr;
    dir_dn_next   = dir_dn;
    we            = 1'b0;
    waddr         = wr_addr;
    wdata         = rdata;
    raddr         = '0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          op_next     = req_code_t'(req.req_type);
          // id is zero-extended or masked to the stored width
          id_next     = ID_WIDTH'(req.win_id);
          status_next = ST_OK;
          unique case (req_code_t'(req.req_type))
            REQ_OPEN: begin
              if (held == CNT_W'(DEPTH)) begin
                status_next = ST_FULL;
                state_next  = S_FRONT;
              end else begin
                // shift every held entry one place back
                cnt_next     = held;
                cur_next     = IDX_W'(held - CNT_W'(1));
                dir_dn_next  = 1'b1;
                wr_pend_next = 1'b0;
                state_next   = S_MOVE;
              end
            end
            REQ_SWITCH, REQ_CLOSE: begin
              if (held == '0) begin
                status_next = ST_EMPTY;
                state_next  = S_FRONT;
              end else begin
                scan_rd_next  = '0;
                cmp_pend_next = 1'b0;
                state_next    = S_SCAN;
              end
            end
            REQ_NOP: begin
              state_next = S_FRONT;
            end
            default: begin
              state_next = S_FRONT;
            end
          endcase
        end
      end

      S_SCAN: begin
        // reads run one ahead of the compare
        raddr = scan_rd[IDX_W-1:0];
        if (cmp_pend && rdata == id) begin
          cmp_pend_next = 1'b0;
          wr_pend_next  = 1'b0;
          if (op == REQ_SWITCH) begin
            // entries in front of the match move back, id goes to front
            cnt_next    = CNT_W'(cmp_idx);
            cur_next    = cmp_idx - IDX_W'(1);
            dir_dn_next = 1'b1;
          end else begin
            // entries behind the match move up one place
            cnt_next    = held - CNT_W'(1) - CNT_W'(cmp_idx);
            cur_next    = cmp_idx + IDX_W'(1);
            dir_dn_next = 1'b0;
          end
          state_next = S_MOVE;
        end else if (scan_rd < held) begin
          cmp_idx_next  = scan_rd[IDX_W-1:0];
          cmp_pend_next = 1'b1;
          scan_rd_next  = scan_rd + CNT_W'(1);
        end else begin
          cmp_pend_next = 1'b0;
          status_next   = ST_NOT_FOUND;
          state_next    = S_FRONT;
        end
      end

      S_MOVE: begin
        // pipelined copy: each entry is read, then written from the registered read data
        raddr = cur;
        if (wr_pend) begin
          we = 1'b1;
        end
        if (cnt != '0) begin
          cur_next     = dir_dn ? cur - IDX_W'(1) : cur + IDX_W'(1);
          wr_addr_next = dir_dn ? cur + IDX_W'(1) : cur - IDX_W'(1);
          cnt_next     = cnt - CNT_W'(1);
          wr_pend_next = 1'b1;
        end else begin
          wr_pend_next = 1'b0;
          if (op == REQ_CLOSE) begin
            held_next  = held - CNT_W'(1);
            state_next = S_FRONT;
          end else begin
            state_next = S_WR0;
          end
        end
      end

      S_WR0: begin
        // new front entry
        we    = 1'b1;
        waddr = '0;
        wdata = id;
        if (op == REQ_OPEN) begin
          held_next = held + CNT_W'(1);
        end
        state_next = S_FRONT;
      end

      S_FRONT: begin
        raddr      = '0;
        state_next = S_RESP;
      end

      S_RESP: begin
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      held     <= '0;
      scan_rd  <= '0;
      cmp_pend <= 1'b0;
      cnt      <= '0;
      wr_pend  <= 1'b0;
    end else begin
      state    <= state_next;
      held     <= held_next;
      scan_rd  <= scan_rd_next;
      cmp_pend <= cmp_pend_next;
      cnt      <= cnt_next;
      wr_pend  <= wr_pend_next;
    end
  end

  // payload of the request in flight
  always_ff @(posedge clk) begin
    op      <= op_next;
    id      <= id_next;
    status  <= status_next;
    cmp_idx <= cmp_idx_next;
    cur     <= cur_next;
    wr_addr <= wr_addr_next;
    dir_dn  <= dir_dn_next;
  end

  // handshake
  assign busy = (state != S_IDLE);
  assign done = (state == S_RESP);

  // result transfer, front entry read in the cycle before
  always_comb begin
    rsp.front_id    = (held != '0) ? 16'(rdata) : 16'd0;
    rsp.list_empty  = (held == '0);
    rsp.entry_count = 5'(held);
    rsp.status      = status;
  end

endmodule

FILE: tb/move_to_front_recency_list_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_to_front_recency_list_tb
// Self-checking bench for the recency list. Requests are queued up front by
// a stimulus block, sent by a falling-edge driver with random gaps, and
// every done result is compared field by field against a shadow list kept
// in the bench. A short directed opener covers empty, full, duplicate and
// miss cases; biased random phases then fill and drain the list repeatedly.
// ----------------------------------------------------------------------------
module move_to_front_recency_list_tb;

  import mtf_pkg::*;

  localparam int unsigned DEPTH     = DEPTH_DEF;
  localparam int unsigned RUN_ITEMS = 1800;
  localparam int unsigned RUN_LIMIT = 400000;
  // worst request is a full scan plus a full shift, so this covers any tail
  localparam int unsigned TAIL_WAIT = 2 * DEPTH + 16;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  req_t  req = '0;
  logic  busy;
  logic  done;
  rsp_t  rsp;

  always #2 clk = ~clk;

  move_to_front_recency_list DUT (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
  );

  // pending requests, with the idle gap after each and a flag that makes the
  // driver hold off until every outstanding result has come back
  req_t        req_q[$];
  int unsigned gap_q[$];
  bit          settle_q[$];
  rsp_t        expected_rsp_q[$];

  int unsigned sent_cnt     = 0;
  int unsigned taken_cnt    = 0;
  int unsigned idle_left    = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned result_cnt   = 0;
  int unsigned status_cnt[4];
  int unsigned peak_held    = 0;
  bit          gap_enable   = 1'b1;

  // shadow of the list contents, front at index 0
  logic [15:0] held_ids[DEPTH];
  int unsigned held_count = 0;

  // apply one request to the shadow list and return the result it must give
  function automatic rsp_t apply_request(req_t r);
    rsp_t    o;
    status_t st;
    int      pos;
    int      i;
    st  = ST_OK;
    pos = -1;
    case (req_code_t'(r.req_type))
      REQ_OPEN: begin
        if (held_count >= DEPTH) begin
          st = ST_FULL;
        end else begin
          for (i = held_count; i > 0; i--) held_ids[i] = held_ids[i-1];
          held_ids[0] = r.win_id;
          held_count++;
        end
      end
      REQ_SWITCH, REQ_CLOSE: begin
        if (held_count == 0) begin
          st = ST_EMPTY;
        end else begin
          // first match counted from the front
          for (i = 0; i < held_count; i++) begin
            if (pos < 0 && held_ids[i] == r.win_id) pos = i;
          end
          if (pos < 0) begin
            st = ST_NOT_FOUND;
          end else if (req_code_t'(r.req_type) == REQ_SWITCH) begin
            for (i = pos; i > 0; i--) held_ids[i] = held_ids[i-1];
            held_ids[0] = r.win_id;
          end else begin
            // entries behind the removed one move up to close the gap
            for (i = pos; i + 1 < held_count; i++) held_ids[i] = held_ids[i+1];
            held_count--;
          end
        end
      end
      default: begin
        // no-op request, list untouched
      end
    endcase
    if (held_count > peak_held) peak_held = held_count;
    o.front_id    = (held_count != 0) ? held_ids[0] : 16'h0000;
    o.list_empty  = (held_count == 0);
    o.entry_count = 5'(held_count);
    o.status      = st;
    return o;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic queue_item(req_code_t op, logic [15:0] id, bit settle);
    req_t r;
    r.req_type = op;
    r.win_id   = id;
    req_q.push_back(r);
    gap_q.push_back(gap_enable ? $urandom_range(0, 4) : 0);
    settle_q.push_back(settle);
  endtask

  // ---------------------------------------------------------------------------
  // driver: a new request goes out on the falling edge once the previous one
  // has been taken (start high and busy low at a rising edge)
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      start     <= 1'b0;
      idle_left <= 0;
    end else if (!start || taken_cnt == sent_cnt) begin
      if (idle_left != 0) begin
        start     <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (req_q.size() == 0) begin
        start <= 1'b0;
      end else if (settle_q[0] && (busy || expected_rsp_q.size() != 0)) begin
        // hold off until the block has drained completely
        start <= 1'b0;
      end else begin
        req       <= req_q.pop_front();
        idle_left <= gap_q.pop_front();
        void'(settle_q.pop_front());
        start     <= 1'b1;
        sent_cnt  <= sent_cnt + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: check results on done, predict on every request transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rsp_t want;
    cycle_cnt <= cycle_cnt + 1;
    if (!rst) begin
      if (done) begin
        if (expected_rsp_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: result with nothing expected, expected none, actual %0h",
                   $time, rsp);
        end else begin
          want = expected_rsp_q.pop_front();
          result_cnt++;
          status_cnt[want.status]++;
          check_field("front_id", want.front_id, rsp.front_id);
          check_field("list_empty", want.list_empty, rsp.list_empty);
          check_field("entry_count", want.entry_count, rsp.entry_count);
          check_field("status", want.status, rsp.status);
        end
      end
      if (start && !busy) begin
        expected_rsp_q.push_back(apply_request(req));
        taken_cnt <= taken_cnt + 1;
      end
    end
  end

  // watchdog
  initial begin
    wait (cycle_cnt >= RUN_LIMIT);
    $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
    $display("move_to_front_recency_list regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    logic [15:0] id_pool[6];
    logic [15:0] id;
    int unsigned total_items;
    int unsigned phase_len;
    int unsigned k;
    int unsigned pick;
    bit          fill_phase;
    req_code_t   op;

    foreach (status_cnt[s]) status_cnt[s] = 0;

    // directed opener: requests on an empty list first
    queue_item(REQ_SWITCH, 16'h1234, 1'b0);
    queue_item(REQ_CLOSE,  16'hFFFF, 1'b0);
    queue_item(REQ_NOP,    16'hFFFF, 1'b0);
    // fill to the top, extremes and duplicates among the ids
    queue_item(REQ_OPEN, 16'h0000, 1'b0);
    queue_item(REQ_OPEN, 16'hFFFF, 1'b0);
    queue_item(REQ_OPEN, 16'h0000, 1'b0);
    queue_item(REQ_OPEN, 16'hA5A5, 1'b0);
    queue_item(REQ_OPEN, 16'h5A5A, 1'b0);
    for (k = 0; k < 10; k++) queue_item(REQ_OPEN, 16'h0100 + 16'(k), 1'b0);
    queue_item(REQ_OPEN, 16'hFFFF, 1'b0);
    // open on a full list is dropped
    queue_item(REQ_OPEN, 16'h7777, 1'b0);
    // nearer 0000 entry to the front, then the front again (no change)
    queue_item(REQ_SWITCH, 16'h0000, 1'b0);
    queue_item(REQ_SWITCH, 16'h0000, 1'b0);
    // miss on switch and close, close from the middle
    queue_item(REQ_SWITCH, 16'h7777, 1'b0);
    queue_item(REQ_CLOSE,  16'h5A5A, 1'b0);
    queue_item(REQ_CLOSE,  16'h7777, 1'b0);

    // random phases, alternating between filling and draining the list;
    // ids come mostly from a small pool so switch and close usually hit
    fill_phase = 1'b0;
    while (req_q.size() < RUN_ITEMS + 25) begin
      phase_len  = $urandom_range(40, 120);
      fill_phase = ~fill_phase;
      gap_enable = ($urandom_range(0, 3) != 0);
      foreach (id_pool[p]) id_pool[p] = 16'($urandom);
      for (k = 0; k < phase_len; k++) begin
        pick = $urandom_range(0, 99);
        if (fill_phase)
          op = req_code_t'((pick < 55) ? REQ_OPEN : (pick < 80) ? REQ_SWITCH :
                           (pick < 95) ? REQ_CLOSE : REQ_NOP);
        else
          op = req_code_t'((pick < 25) ? REQ_OPEN : (pick < 50) ? REQ_SWITCH :
                           (pick < 95) ? REQ_CLOSE : REQ_NOP);
        id = ($urandom_range(0, 9) < 8) ? id_pool[$urandom_range(0, 5)]
                                         : 16'($urandom);
        // each phase starts from a drained block
        queue_item(op, id, (k == 0) || ($urandom_range(0, 199) == 0));
      end
    end
    total_items = req_q.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (taken_cnt != total_items) @(posedge clk);
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("%0d requests, %0d results checked, list reached %0d of %0d entries",
             taken_cnt, result_cnt, peak_held, DEPTH);
    $display("status mix: ok %0d, not found %0d, full %0d, empty %0d",
             status_cnt[ST_OK], status_cnt[ST_NOT_FOUND], status_cnt[ST_FULL],
             status_cnt[ST_EMPTY]);
    if (mismatch_cnt == 0) begin
      $display("move_to_front_recency_list regression: pass");
    end else begin
      $display("move_to_front_recency_list regression: fail");
    end
    $finish;
  end

endmodule

FILE: move_to_front_recency_list.f
hdl/mtf_pkg.sv
hdl/mtf_ram.sv
hdl/move_to_front_recency_list.sv
tb/move_to_front_recency_list_tb.sv
